>>> hw/rtl/dsag_pkg.sv
// Shared types and constants of the diagnostic security access gate.
// Used by the configuration registers, the evaluation engine and the top level.
package dsag_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0] MIN_REQ_LEN  = 8'd2;
  localparam logic [7:0] SEED_REQ_LEN = 8'd2;
  localparam logic [7:0] KEY_REQ_LEN  = 8'd6;
  localparam logic [7:0] FAIL_SAT     = 8'hFF;

  localparam logic [1:0] LVL_LOCKED = 2'd0;
  localparam logic [1:0] LVL_ONE    = 2'd1;
  localparam logic [1:0] LVL_TWO    = 2'd2;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_LOCK    = 2'd2
  } dsag_cmd_t;

  typedef enum logic [2:0] {
    RSP_POSITIVE    = 3'd0,
    RSP_BAD_LENGTH  = 3'd1,
    RSP_BAD_SUB     = 3'd2,
    RSP_BAD_SESSION = 3'd3,
    RSP_DELAY       = 3'd4,
    RSP_BAD_KEY     = 3'd5
  } dsag_rsp_t;

  typedef struct packed {
    logic [31:0] seed_value;
    logic [31:0] expected_key;
    logic [7:0]  max_failed_attempts;
    logic [23:0] lockout_ticks;
    logic [6:0]  level_one_seed_sub;
    logic [6:0]  level_two_seed_sub;
    logic [7:0]  extended_session_code;
    logic [7:0]  programming_session_code;
  } dsag_cfg_t;

  typedef struct packed {
    dsag_cmd_t   cmd;
    logic [7:0]  msg_len;
    logic [7:0]  sub_function;
    logic [31:0] offered_key;
    logic [7:0]  session_code;
  } dsag_item_t;

  typedef struct packed {
    dsag_rsp_t   response_code;
    logic [7:0]  echo_sub;
    logic [31:0] seed_out;
    logic [2:0]  response_length;
    logic [1:0]  access_level;
  } dsag_result_t;

endpackage

>>> hw/rtl/dsag_cfg_regs.sv
// Configuration register file of the security access gate.
// Depends on dsag_pkg for the register bundle type and port widths.
module dsag_cfg_regs
  import dsag_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output dsag_cfg_t             cfg
);

  localparam logic [CFG_ADDR_W-1:0] REG_SEED_VALUE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_EXP_KEY     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_FAIL    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LOCK_TICKS  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_L1_SUB      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_L2_SUB      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_EXT_SESSION = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_PRG_SESSION = 3'd7;

  dsag_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed_value               <= 32'd0;
      cfg_r.expected_key             <= 32'd0;
      cfg_r.max_failed_attempts      <= 8'd3;
      cfg_r.lockout_ticks            <= 24'd10000;
      cfg_r.level_one_seed_sub       <= 7'd1;
      cfg_r.level_two_seed_sub       <= 7'd3;
      cfg_r.extended_session_code    <= 8'd3;
      cfg_r.programming_session_code <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SEED_VALUE:  cfg_r.seed_value               <= cfg_wdata;
        REG_EXP_KEY:     cfg_r.expected_key             <= cfg_wdata;
        REG_MAX_FAIL:    cfg_r.max_failed_attempts      <= cfg_wdata[7:0];
        REG_LOCK_TICKS:  cfg_r.lockout_ticks            <= cfg_wdata[23:0];
        REG_L1_SUB:      cfg_r.level_one_seed_sub       <= cfg_wdata[6:0];
        REG_L2_SUB:      cfg_r.level_two_seed_sub       <= cfg_wdata[6:0];
        REG_EXT_SESSION: cfg_r.extended_session_code    <= cfg_wdata[7:0];
        REG_PRG_SESSION: cfg_r.programming_session_code <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/dsag_engine.sv
// Evaluation engine: checks one request, tick or lock command against the gate state.
// Holds the access level, failure count, seed and lockout countdown; uses dsag_pkg.
module dsag_engine
  import dsag_pkg::*;
#(
  parameter int SEED_BYTES = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  dsag_item_t   item,
  input  dsag_cfg_t    cfg,
  output logic         has_result,
  output dsag_result_t result
);

  localparam int         POS_LEN_I = (1 + SEED_BYTES > 7) ? 7 : 1 + SEED_BYTES;
  localparam logic [2:0] POS_LEN   = 3'(POS_LEN_I);
  localparam logic [63:0] MASK64   = (64'd1 << (8 * SEED_BYTES)) - 64'd1;
  localparam logic [31:0] SEED_MASK = (SEED_BYTES >= 4) ? 32'hFFFF_FFFF : MASK64[31:0];

  logic [1:0]  level_r, level_nxt;
  logic [7:0]  fail_r, fail_nxt;
  logic [31:0] seed_r, seed_nxt;
  logic [23:0] remain_r, remain_nxt;
  logic        running_r, running_nxt;

  logic [6:0]  dec;
  logic [7:0]  key1, key2;
  logic        is_s1, is_s2, is_k1, is_k2, is_seed, is_key;
  logic [7:0]  fail_inc;
  dsag_rsp_t   code;

  always_comb begin
    dec   = item.sub_function[6:0];
    key1  = {1'b0, cfg.level_one_seed_sub} + 8'd1;
    key2  = {1'b0, cfg.level_two_seed_sub} + 8'd1;
    is_s1 = (dec == cfg.level_one_seed_sub);
    is_s2 = (dec == cfg.level_two_seed_sub);
    is_k1 = ({1'b0, dec} == key1);
    is_k2 = ({1'b0, dec} == key2);
    is_seed = is_s1 || is_s2;
    is_key  = is_k1 || is_k2;
    fail_inc = (fail_r == FAIL_SAT) ? FAIL_SAT : fail_r + 8'd1;

    if (item.msg_len < MIN_REQ_LEN) begin
      code = RSP_BAD_LENGTH;
    end else if (is_seed && item.msg_len != SEED_REQ_LEN) begin
      code = RSP_BAD_LENGTH;
    end else if (is_key && item.msg_len != KEY_REQ_LEN) begin
      code = RSP_BAD_LENGTH;
    end else if ((is_k1 || is_s1) && item.session_code != cfg.extended_session_code) begin
      code = RSP_BAD_SESSION;
    end else if ((is_k2 || is_s2) && item.session_code != cfg.programming_session_code) begin
      code = RSP_BAD_SESSION;
    end else if (running_r) begin
      code = RSP_DELAY;
    end else if (!is_seed && !is_key) begin
      code = RSP_BAD_SUB;
    end else if (is_seed) begin
      code = RSP_POSITIVE;
    end else if (item.offered_key != cfg.expected_key) begin
      code = RSP_BAD_KEY;
    end else begin
      code = RSP_POSITIVE;
    end

    level_nxt   = level_r;
    fail_nxt    = fail_r;
    seed_nxt    = seed_r;
    remain_nxt  = remain_r;
    running_nxt = running_r;
    has_result  = 1'b0;

    case (item.cmd)
      CMD_REQUEST: begin
        has_result = 1'b1;
        if (code == RSP_POSITIVE && is_seed) begin
          if ((is_s1 && level_r == LVL_ONE) || (is_s2 && level_r == LVL_TWO)) begin
            seed_nxt = 32'd0;
          end else begin
            seed_nxt = cfg.seed_value;
          end
        end else if (code == RSP_BAD_KEY) begin
          fail_nxt = fail_inc;
          if (fail_inc >= cfg.max_failed_attempts) begin
            remain_nxt  = cfg.lockout_ticks;
            running_nxt = 1'b1;
          end
        end else if (code == RSP_POSITIVE) begin
          fail_nxt    = 8'd0;
          running_nxt = 1'b0;
          remain_nxt  = 24'd0;
          level_nxt   = is_k1 ? LVL_ONE : LVL_TWO;
        end
      end
      CMD_TICK: begin
        if (running_r) begin
          if (remain_r > 24'd1) begin
            remain_nxt = remain_r - 24'd1;
          end else begin
            remain_nxt  = 24'd0;
            running_nxt = 1'b0;
            if (fail_r != 8'd0) fail_nxt = fail_r - 8'd1;
          end
        end
      end
      CMD_LOCK: level_nxt = LVL_LOCKED;
      default: ;
    endcase

    result.response_code = code;
    result.access_level  = level_nxt;
    if (code == RSP_POSITIVE) begin
      result.echo_sub        = item.sub_function;
      result.seed_out        = seed_nxt & SEED_MASK;
      result.response_length = POS_LEN;
    end else begin
      result.echo_sub        = 8'd0;
      result.seed_out        = 32'd0;
      result.response_length = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= LVL_LOCKED;
      fail_r    <= 8'd0;
      seed_r    <= 32'hFFFF_FFFF;
      remain_r  <= 24'd0;
      running_r <= 1'b0;
    end else if (fire) begin
      level_r   <= level_nxt;
      fail_r    <= fail_nxt;
      seed_r    <= seed_nxt;
      remain_r  <= remain_nxt;
      running_r <= running_nxt;
    end
  end

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> remain_r == 24'd0)
    else $error("Lockout countdown is nonzero while no lockout runs.");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r == LVL_LOCKED || level_r == LVL_ONE || level_r == LVL_TWO)
    else $error("Access level holds an undefined code.");

  a_last_tick_ends: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.cmd == CMD_TICK && running_r && remain_r <= 24'd1 |=> !running_r)
    else $error("Final lockout tick did not end the lockout.");

  a_lock_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.cmd == CMD_LOCK |=> level_r == LVL_LOCKED)
    else $error("Lock command left an access level open.");

endmodule

>>> hw/rtl/diagnostic_security_access_gate.sv
// Seed/key security access gate with an input stage, an evaluation engine and a result register.
// Instantiates dsag_cfg_regs and dsag_engine; uses dsag_pkg.
//
// The gate takes one beat per clock cycle, whether a request, a timer tick or a lock command.
// A request beat passes the input register and the engine into the result register, which gives
// its response beat; ticks and lock commands update the gate state and give no response.
// The single evaluation stage between the input and result registers sets the rate of one beat
// per cycle; a waiting response stalls input only while a request is in the input register.
module diagnostic_security_access_gate
  import dsag_pkg::*;
#(
  parameter int SEED_BYTES = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // msg_len[7:0], sub_function[15:8], offered_key[47:16], session_code[55:48]
  input  logic [55:0]           in_tdata,
  // cmd[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // response_code[2:0], echo_sub[10:3], seed_out[42:11], response_length[45:43],
  // access_level[47:46]
  output logic [47:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dsag_cfg_t    cfg;
  dsag_item_t   item_r;
  logic         in_valid_r;
  logic         out_valid_r;
  dsag_result_t res_r;
  dsag_result_t result;
  logic         has_result;
  logic         advance;

  dsag_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dsag_engine #(
    .SEED_BYTES (SEED_BYTES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .item       (item_r),
    .cfg        (cfg),
    .has_result (has_result),
    .result     (result)
  );

  assign advance   = in_valid_r && (!has_result || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.cmd          <= dsag_cmd_t'(in_tuser);
      item_r.msg_len      <= in_tdata[7:0];
      item_r.sub_function <= in_tdata[15:8];
      item_r.offered_key  <= in_tdata[47:16];
      item_r.session_code <= in_tdata[55:48];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.access_level, res_r.response_length, res_r.seed_out,
                       res_r.echo_sub, res_r.response_code};

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(advance && has_result))
    else $error("A waiting response beat was overwritten.");

  a_negative_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.response_code != RSP_POSITIVE |->
      res_r.response_length == 3'd0 && res_r.echo_sub == 8'd0 && res_r.seed_out == 32'd0)
    else $error("Negative response carries payload bytes.");

endmodule
